### sv/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants for the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int HUE_W       = 16;
    localparam int CHAN_W      = 8;
    localparam int SV_W        = 9;
    localparam int NUM_STAGES  = 10;

    // Chroma and offset use 16 fraction bits, 65536 = 1.0
    localparam int CHROMA_W    = 17;
    localparam logic [SV_W-1:0] SV_ONE = 9'd256;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b1;
    localparam logic [CFG_DATA_W-1:0] SATURATION_RST = 9'd154;
    localparam logic [CFG_DATA_W-1:0] BRIGHTNESS_RST = 9'd220;

    // Scaled second component before the final divide by 15 stays below 15 * 256
    localparam int VAL_W       = 12;
    // floor(x / 15) == (x * 2185) >> 15 for every x below 3840
    localparam int DIV15_RECIP = 2185;
    localparam int DIV15_SH    = 15;
    localparam int DIV15_W     = 24;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } hue_sector_t;

endpackage

### sv/hsv_pipe_ctl.sv
// ----------------------------------------------------------------------------
// hsv_pipe_ctl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module hsv_pipe_ctl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output hsv_pkg::stage_en_t en
);

    localparam int N = hsv_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;

    // A stage may load when it or any stage after it is empty, or the sink takes
    for (genvar i = 0; i < N; i++) begin : g_en
        assign en[i] = m_ready | ~(&valid_reg[N-1:i]);
    end

    always_comb begin
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < N; i++) begin
            if (en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[N-1];

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted word did not enter the first stage");

    a_word_count: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> ($countones(valid_reg) == $past($countones(valid_reg))
            + ($past(s_valid && s_ready) ? 1 : 0) - ($past(m_valid && m_ready) ? 1 : 0)))
        else $error("word lost or duplicated in the pipeline");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_ready |-> !s_ready)
        else $error("input taken while every stage is full and stalled");

    a_bubble_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> s_ready)
        else $error("input refused although the first stage is empty");
`endif

endmodule

### sv/hsv_hue.sv
// ----------------------------------------------------------------------------
// hsv_hue
// Hue reduction into one turn, sector search and distance to the even boundary.
// Stages 1 to 6 of the pipeline.
// ----------------------------------------------------------------------------
module hsv_hue #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                              aclk,
    input  hsv_pkg::stage_en_t                en,
    input  logic signed [hsv_pkg::HUE_W-1:0]  hue,
    output hsv_pkg::hue_sector_t              sector,
    output logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0] k
);

    localparam int FULL_TURN = 360 << HUE_FRAC_BITS;
    localparam int SEC       = 60 << HUE_FRAC_BITS;
    localparam int SEC_W     = $clog2(SEC + 1);
    localparam int F_W       = $clog2(SEC);
    localparam int HM_W      = $clog2(FULL_TURN);
    localparam int FT_W      = $clog2(FULL_TURN + 1);
    // Smallest multiple of a turn that lifts every hue to zero or above
    localparam int OFFSET    = ((32768 + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
    localparam int U_W       = $clog2(32767 + OFFSET + 1);
    // Quotient estimate is exact or one low because u < 2^U_W
    localparam int R_TURN    = (1 << U_W) / FULL_TURN;
    localparam int R_W       = $clog2(R_TURN + 1);
    localparam int TP_W      = U_W + FT_W;

    // Stage 1
    logic [U_W-1:0]       u1_reg, u1_next;
    // Stage 2
    logic [U_W+R_W-1:0]   p2_reg, p2_next;
    logic [U_W-1:0]       u2_reg;
    // Stage 3
    logic [U_W-1:0]       tprod3_reg, tprod3_next;
    logic [U_W-1:0]       u3_reg;
    // Stage 4
    logic [HM_W-1:0]      hm4_reg, hm4_next;
    // Stage 5
    hsv_pkg::hue_sector_t sector5_reg, sector5_next;
    logic [F_W-1:0]       f5_reg, f5_next;
    // Stage 6
    hsv_pkg::hue_sector_t sector6_reg;
    logic [SEC_W-1:0]     k6_reg, k6_next;

    logic [R_W-1:0]       t3;
    logic [TP_W-1:0]      tprod_full;
    logic [U_W-1:0]       r1;
    logic [U_W:0]         r2;
    logic [HM_W-1:0]      base5;
    logic [HM_W-1:0]      diff5;
    logic                 odd5;

    always_comb begin
        u1_next = {{(U_W-hsv_pkg::HUE_W){hue[hsv_pkg::HUE_W-1]}}, hue} + U_W'(OFFSET);

        p2_next = (U_W+R_W)'(u1_reg) * (U_W+R_W)'(R_TURN);

        t3          = p2_reg[U_W +: R_W];
        tprod_full  = TP_W'(t3) * TP_W'(FULL_TURN);
        tprod3_next = tprod_full[U_W-1:0];

        // One correction step brings the remainder below a full turn
        r1       = u3_reg - tprod3_reg;
        r2       = {1'b0, r1} - (U_W+1)'(FULL_TURN);
        hm4_next = r2[U_W] ? r1[HM_W-1:0] : r2[HM_W-1:0];

        if (hm4_reg >= HM_W'(5 * SEC)) begin
            sector5_next = hsv_pkg::SEC_M_TO_R;
            base5        = HM_W'(5 * SEC);
        end else if (hm4_reg >= HM_W'(4 * SEC)) begin
            sector5_next = hsv_pkg::SEC_B_TO_M;
            base5        = HM_W'(4 * SEC);
        end else if (hm4_reg >= HM_W'(3 * SEC)) begin
            sector5_next = hsv_pkg::SEC_C_TO_B;
            base5        = HM_W'(3 * SEC);
        end else if (hm4_reg >= HM_W'(2 * SEC)) begin
            sector5_next = hsv_pkg::SEC_G_TO_C;
            base5        = HM_W'(2 * SEC);
        end else if (hm4_reg >= HM_W'(SEC)) begin
            sector5_next = hsv_pkg::SEC_Y_TO_G;
            base5        = HM_W'(SEC);
        end else begin
            sector5_next = hsv_pkg::SEC_R_TO_Y;
            base5        = '0;
        end
        diff5  = hm4_reg - base5;
        f5_next = diff5[F_W-1:0];

        odd5 = (sector5_reg == hsv_pkg::SEC_Y_TO_G) || (sector5_reg == hsv_pkg::SEC_C_TO_B)
            || (sector5_reg == hsv_pkg::SEC_M_TO_R);
        k6_next = odd5 ? (SEC_W'(SEC) - SEC_W'(f5_reg)) : SEC_W'(f5_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            u1_reg <= u1_next;
        end
        if (en[1]) begin
            p2_reg <= p2_next;
            u2_reg <= u1_reg;
        end
        if (en[2]) begin
            tprod3_reg <= tprod3_next;
            u3_reg     <= u2_reg;
        end
        if (en[3]) begin
            hm4_reg <= hm4_next;
        end
        if (en[4]) begin
            sector5_reg <= sector5_next;
            f5_reg      <= f5_next;
        end
        if (en[5]) begin
            sector6_reg <= sector5_reg;
            k6_reg      <= k6_next;
        end
    end

    assign sector = sector6_reg;
    assign k      = k6_reg;

endmodule

### sv/hsv_chan.sv
// ----------------------------------------------------------------------------
// hsv_chan
// Chroma and offset from the configuration, second component, scaling to
// 8-bit channels and placement by sector. Stages 1 to 10 of the pipeline.
// ----------------------------------------------------------------------------
module hsv_chan #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                               aclk,
    input  hsv_pkg::stage_en_t                 en,
    input  logic [hsv_pkg::SV_W-1:0]           saturation,
    input  logic [hsv_pkg::SV_W-1:0]           brightness,
    input  hsv_pkg::hue_sector_t               sector,
    input  logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0] k,
    output logic [hsv_pkg::CHAN_W-1:0]         red,
    output logic [hsv_pkg::CHAN_W-1:0]         green,
    output logic [hsv_pkg::CHAN_W-1:0]         blue
);

    localparam int SEC     = 60 << HUE_FRAC_BITS;
    localparam int SEC_W   = $clog2(SEC + 1);
    localparam int CW      = hsv_pkg::CHROMA_W;
    localparam int CH      = hsv_pkg::CHAN_W;
    localparam int MS_W    = CW + SEC_W;
    localparam int SUM_W   = 16 + SEC_W;
    localparam int P9_W    = SUM_W + 8;
    // 65536 * SEC = 15 * 2^(18 + HUE_FRAC_BITS)
    localparam int X_SH    = 18 + HUE_FRAC_BITS;
    localparam int VAL_W   = hsv_pkg::VAL_W;
    localparam int QP_W    = hsv_pkg::DIV15_W;

    // Stage 1
    logic [hsv_pkg::SV_W-1:0] v1_reg, v1_next;
    logic [CW-1:0]            c1_reg, c1_next;
    // Stage 2
    logic [CW-1:0]            c2_reg, m2_reg, m2_next;
    logic [CH-1:0]            full2_reg, full2_next;
    // Stage 3 to 9 carry
    logic [CW-1:0]            c3_reg, c4_reg, c5_reg, c6_reg;
    logic [MS_W-1:0]          ms3_reg, ms4_reg, ms5_reg, ms6_reg, ms7_reg, ms3_next;
    logic [CH-1:0]            zero3_reg, zero3_next;
    logic [CH-1:0]            full3_reg, full4_reg, full5_reg, full6_reg;
    logic [CH-1:0]            full7_reg, full8_reg, full9_reg;
    logic [CH-1:0]            zero4_reg, zero5_reg, zero6_reg;
    logic [CH-1:0]            zero7_reg, zero8_reg, zero9_reg;
    // Stage 7 to 9
    hsv_pkg::hue_sector_t     sector7_reg, sector8_reg, sector9_reg;
    logic [MS_W-1:0]          xk7_reg, xk7_next;
    logic [SUM_W-1:0]         sum8_reg, sum8_next;
    logic [VAL_W-1:0]         val9_reg, val9_next;
    // Stage 10
    logic [CH-1:0]            red_reg, green_reg, blue_reg;
    logic [CH-1:0]            red_next, green_next, blue_next;

    logic [hsv_pkg::SV_W-1:0] s_cl, v_cl;
    logic [2*hsv_pkg::SV_W-1:0] sv_prod;
    logic [CW-1:0]            vp;
    logic [24:0]              mp;
    logic [P9_W-1:0]          p9;
    logic [QP_W-1:0]          q10;
    logic [CH-1:0]            x10;

    always_comb begin
        // Registers above 1.0 saturate to 1.0
        s_cl    = (saturation > hsv_pkg::SV_ONE) ? hsv_pkg::SV_ONE : saturation;
        v_cl    = (brightness > hsv_pkg::SV_ONE) ? hsv_pkg::SV_ONE : brightness;
        sv_prod = (2*hsv_pkg::SV_W)'(s_cl) * (2*hsv_pkg::SV_W)'(v_cl);
        c1_next = sv_prod[CW-1:0];
        v1_next = v_cl;

        m2_next    = {v1_reg[CW-9:0], 8'd0} - c1_reg;
        vp         = CW'(v1_reg) * CW'(255);
        full2_next = vp[15:8];

        mp         = 25'(m2_reg) * 25'd255;
        zero3_next = mp[23:16];
        ms3_next   = MS_W'(m2_reg) * MS_W'(SEC);

        xk7_next  = MS_W'(c6_reg) * MS_W'(k);
        sum8_next = SUM_W'(xk7_reg) + SUM_W'(ms7_reg);
        p9        = P9_W'(sum8_reg) * P9_W'(255);
        val9_next = p9[X_SH +: VAL_W];

        q10 = QP_W'(val9_reg) * QP_W'(hsv_pkg::DIV15_RECIP);
        x10 = q10[hsv_pkg::DIV15_SH +: CH];

        case (sector9_reg)
            hsv_pkg::SEC_R_TO_Y: begin
                red_next = full9_reg; green_next = x10;       blue_next = zero9_reg;
            end
            hsv_pkg::SEC_Y_TO_G: begin
                red_next = x10;       green_next = full9_reg; blue_next = zero9_reg;
            end
            hsv_pkg::SEC_G_TO_C: begin
                red_next = zero9_reg; green_next = full9_reg; blue_next = x10;
            end
            hsv_pkg::SEC_C_TO_B: begin
                red_next = zero9_reg; green_next = x10;       blue_next = full9_reg;
            end
            hsv_pkg::SEC_B_TO_M: begin
                red_next = x10;       green_next = zero9_reg; blue_next = full9_reg;
            end
            default: begin
                red_next = full9_reg; green_next = zero9_reg; blue_next = x10;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            v1_reg <= v1_next;
            c1_reg <= c1_next;
        end
        if (en[1]) begin
            c2_reg    <= c1_reg;
            m2_reg    <= m2_next;
            full2_reg <= full2_next;
        end
        if (en[2]) begin
            c3_reg    <= c2_reg;
            ms3_reg   <= ms3_next;
            zero3_reg <= zero3_next;
            full3_reg <= full2_reg;
        end
        if (en[3]) begin
            c4_reg    <= c3_reg;
            ms4_reg   <= ms3_reg;
            zero4_reg <= zero3_reg;
            full4_reg <= full3_reg;
        end
        if (en[4]) begin
            c5_reg    <= c4_reg;
            ms5_reg   <= ms4_reg;
            zero5_reg <= zero4_reg;
            full5_reg <= full4_reg;
        end
        if (en[5]) begin
            c6_reg    <= c5_reg;
            ms6_reg   <= ms5_reg;
            zero6_reg <= zero5_reg;
            full6_reg <= full5_reg;
        end
        if (en[6]) begin
            xk7_reg     <= xk7_next;
            ms7_reg     <= ms6_reg;
            zero7_reg   <= zero6_reg;
            full7_reg   <= full6_reg;
            sector7_reg <= sector;
        end
        if (en[7]) begin
            sum8_reg    <= sum8_next;
            zero8_reg   <= zero7_reg;
            full8_reg   <= full7_reg;
            sector8_reg <= sector7_reg;
        end
        if (en[8]) begin
            val9_reg    <= val9_next;
            zero9_reg   <= zero8_reg;
            full9_reg   <= full8_reg;
            sector9_reg <= sector8_reg;
        end
        if (en[9]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

### sv/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts a signed hue word to an 8-bit RGB triple with saturation and
// brightness taken from two configuration registers.
// ----------------------------------------------------------------------------
// Takes one hue word per clock while the output is not stalled, and returns
// one RGB word per hue, in order. The ten register stages are hue offset,
// turn quotient multiply, turn product, remainder correction, sector search,
// boundary distance, chroma multiply, offset add, scale by 255 and divide by
// 15 with channel placement. A stalled output keeps flowing into empty
// stages, so the input stays ready while any stage holds a bubble.
// Saturation and brightness use 256 as 1.0; values above 256 act as 256.
// Write them only while no word is in flight.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [hsv_pkg::HUE_W-1:0]    s_hue,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hsv_pkg::CHAN_W-1:0]          m_red,
    output logic [hsv_pkg::CHAN_W-1:0]          m_green,
    output logic [hsv_pkg::CHAN_W-1:0]          m_blue,
    input  logic                                cfg_wr_en,
    input  logic [hsv_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [hsv_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int SEC_W = $clog2((60 << HUE_FRAC_BITS) + 1);

    logic [hsv_pkg::SV_W-1:0] saturation_reg, saturation_next;
    logic [hsv_pkg::SV_W-1:0] brightness_reg, brightness_next;

    hsv_pkg::stage_en_t   en;
    hsv_pkg::hue_sector_t sector;
    logic [SEC_W-1:0]     k;

    always_comb begin
        saturation_next = saturation_reg;
        brightness_next = brightness_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                hsv_pkg::CFG_SATURATION: saturation_next = cfg_wr_data;
                hsv_pkg::CFG_BRIGHTNESS: brightness_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saturation_reg <= hsv_pkg::SATURATION_RST;
            brightness_reg <= hsv_pkg::BRIGHTNESS_RST;
        end else begin
            saturation_reg <= saturation_next;
            brightness_reg <= brightness_next;
        end
    end

    hsv_pipe_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .en      (en)
    );

    hsv_hue #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_hue (
        .aclk   (aclk),
        .en     (en),
        .hue    (s_hue),
        .sector (sector),
        .k      (k)
    );

    hsv_chan #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_chan (
        .aclk       (aclk),
        .en         (en),
        .saturation (saturation_reg),
        .brightness (brightness_reg),
        .sector     (sector),
        .k          (k),
        .red        (m_red),
        .green      (m_green),
        .blue       (m_blue)
    );

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for hsv_to_rgb_converter.
// ----------------------------------------------------------------------------
// Drives hue words through the valid/ready input and checks every RGB word
// against a listed value or a bit-exact fixed-point predictor. A directed
// table covers the sector corners, hue wrap, out-of-range levels and the
// reset levels. Random phases follow, each with new saturation and brightness
// written while the pipeline is empty. Both sides idle at random, and the
// output holds off once long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_W          = hsv_pkg::HUE_W;
    localparam int CHAN_W         = hsv_pkg::CHAN_W;
    localparam int SV_W           = hsv_pkg::SV_W;
    localparam int CFG_IDX_W      = hsv_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = hsv_pkg::CFG_DATA_W;
    localparam int HUE_FRAC       = 6;
    localparam int SEC            = 60 << HUE_FRAC;
    localparam int FULL_TURN      = 360 << HUE_FRAC;
    localparam int NUM_DIR        = 25;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_WORDS    = 188;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_WORD   = 300;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        rgb_t                    rgb;
    } rgb_entry_t;

    typedef struct packed {
        logic [SV_W-1:0]         sat;
        logic [SV_W-1:0]         bri;
        logic signed [HUE_W-1:0] hue;
        bit                      known;
        rgb_t                    rgb;
    } dir_row_t;

    // hue is in 1/64 degree: 3840 = 60 deg, 23040 = 360 deg
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{9'd154, 9'd220,      0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd154, 9'd220,     -1, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd154, 9'd220,   1920, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd256, 9'd256,      0, 1'b1, '{8'd255, 8'd0,   8'd0  }},
        '{9'd256, 9'd256,   3840, 1'b1, '{8'd255, 8'd255, 8'd0  }},
        '{9'd256, 9'd256,   7680, 1'b1, '{8'd0,   8'd255, 8'd0  }},
        '{9'd256, 9'd256,  11520, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{9'd256, 9'd256,  15360, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{9'd256, 9'd256,  19200, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{9'd256, 9'd256,  23040, 1'b1, '{8'd255, 8'd0,   8'd0  }},
        '{9'd256, 9'd256, -23040, 1'b1, '{8'd255, 8'd0,   8'd0  }},
        '{9'd256, 9'd256,  -3840, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{9'd256, 9'd256,   1920, 1'b1, '{8'd255, 8'd127, 8'd0  }},
        '{9'd256, 9'd256,   3839, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd256, 9'd256,  32767, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd256, 9'd256, -32768, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd256, 9'd256,     -1, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd511, 9'd511,   7680, 1'b1, '{8'd0,   8'd255, 8'd0  }},
        '{9'd511, 9'd511,   5000, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd256, 9'd0,     1920, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{9'd256, 9'd0,   -32768, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{9'd0,   9'd256,   9000, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{9'd0,   9'd128,   4000, 1'b1, '{8'd127, 8'd127, 8'd127}},
        '{9'd300, 9'd200,  12345, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd1,   9'd1,   -12345, 1'b0, '{8'd0,   8'd0,   8'd0  }}
    };

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [HUE_W-1:0] s_hue;
    logic                    m_valid;
    logic                    m_ready;
    logic [CHAN_W-1:0]       m_red;
    logic [CHAN_W-1:0]       m_green;
    logic [CHAN_W-1:0]       m_blue;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_wr_index;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;

    logic [SV_W-1:0] sat_level = hsv_pkg::SATURATION_RST;
    logic [SV_W-1:0] bri_level = hsv_pkg::BRIGHTNESS_RST;
    rgb_entry_t      rgb_expected [$];
    int              fail_count   = 0;
    int              words_out    = 0;
    int              stall_cycles = 0;
    bit              tx_eager     = 1'b0;
    bit              rx_eager     = 1'b0;

    always #10 aclk = ~aclk;

    hsv_to_rgb_converter #(
        .HUE_FRAC_BITS(HUE_FRAC)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic logic [CHAN_W-1:0] scale_channel(longint unsigned comp,
                                                       longint unsigned offs);
        longint unsigned q;
        q = ((comp + offs) * 255) / (longint'(65536) * SEC);
        return (q > 255) ? 8'd255 : CHAN_W'(q);
    endfunction

    function automatic rgb_t hsv_to_rgb_predict(logic signed [HUE_W-1:0] hue,
                                               logic [SV_W-1:0] sat,
                                               logic [SV_W-1:0] bri);
        int              wrapped;
        longint unsigned sector, f, k, s, v, c, cs, xs, ms;
        rgb_t            rgb;
        wrapped = int'(hue) % FULL_TURN;
        if (wrapped < 0) begin
            wrapped += FULL_TURN;
        end
        sector = longint'(wrapped) / SEC;
        f      = longint'(wrapped) - sector * SEC;
        k      = sector[0] ? (SEC - f) : f;
        // levels above 1.0 act as 1.0
        s  = (sat > hsv_pkg::SV_ONE) ? hsv_pkg::SV_ONE : sat;
        v  = (bri > hsv_pkg::SV_ONE) ? hsv_pkg::SV_ONE : bri;
        c  = s * v;
        cs = c * SEC;
        xs = c * k;
        ms = (v * 256 - c) * SEC;
        case (hsv_pkg::hue_sector_t'(sector))
            hsv_pkg::SEC_R_TO_Y: begin
                rgb = '{scale_channel(cs, ms), scale_channel(xs, ms), scale_channel(0, ms)};
            end
            hsv_pkg::SEC_Y_TO_G: begin
                rgb = '{scale_channel(xs, ms), scale_channel(cs, ms), scale_channel(0, ms)};
            end
            hsv_pkg::SEC_G_TO_C: begin
                rgb = '{scale_channel(0, ms), scale_channel(cs, ms), scale_channel(xs, ms)};
            end
            hsv_pkg::SEC_C_TO_B: begin
                rgb = '{scale_channel(0, ms), scale_channel(xs, ms), scale_channel(cs, ms)};
            end
            hsv_pkg::SEC_B_TO_M: begin
                rgb = '{scale_channel(xs, ms), scale_channel(0, ms), scale_channel(cs, ms)};
            end
            default: begin
                rgb = '{scale_channel(cs, ms), scale_channel(0, ms), scale_channel(xs, ms)};
            end
        endcase
        return rgb;
    endfunction

    function automatic logic signed [HUE_W-1:0] pick_hue();
        int sel;
        int k;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return HUE_W'($urandom);
        end
        if (sel <= 2) begin
            // land on or next to a sector boundary
            k = int'($urandom_range(0, 12)) - 6;
            return HUE_W'(k * SEC + int'($urandom_range(0, 4)) - 2);
        end
        return HUE_W'(int'($urandom_range(0, 46078)) - 23039);
    endfunction

    function automatic logic [SV_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return hsv_pkg::SV_ONE;
            2:       return SV_W'($urandom_range(257, 511));
            default: return SV_W'($urandom_range(0, 256));
        endcase
    endfunction

    function automatic void note_failure(string msg);
        if (fail_count < 10) begin
            $display("%s", msg);
        end
        fail_count++;
    endfunction

    // Offer one hue word, then record its expected color once accepted.
    task automatic send_hue(logic signed [HUE_W-1:0] hue, bit known, rgb_t rgb);
        int         gap;
        rgb_entry_t entry;
        gap = tx_eager ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_hue   <= hue;
        do @(posedge aclk); while (!s_ready);
        entry.hue = hue;
        entry.rgb = known ? rgb : hsv_to_rgb_predict(hue, sat_level, bri_level);
        rgb_expected.insert(rgb_expected.size(), entry);
    endtask

    // Drop valid and wait for the pipeline to empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (rgb_expected.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic load_levels(logic [SV_W-1:0] sat, logic [SV_W-1:0] bri);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= hsv_pkg::CFG_SATURATION;
        cfg_wr_data  <= sat;
        @(posedge aclk);
        cfg_wr_index <= hsv_pkg::CFG_BRIGHTNESS;
        cfg_wr_data  <= bri;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sat_level = sat;
        bri_level = bri;
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_hue        <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= hsv_pkg::CFG_SATURATION;
        cfg_wr_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int row = 0; row < NUM_DIR; row++) begin
            if (DIR_ROWS[row].sat != sat_level || DIR_ROWS[row].bri != bri_level) begin
                settle();
                load_levels(DIR_ROWS[row].sat, DIR_ROWS[row].bri);
            end
            send_hue(DIR_ROWS[row].hue, DIR_ROWS[row].known, DIR_ROWS[row].rgb);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            load_levels(pick_level(), pick_level());
            tx_eager = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_hue(pick_hue(), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (rgb_expected.size() != 0) begin
            note_failure($sformatf("no output word for hue %0d", rgb_expected[0].hue));
            void'(rgb_expected.pop_front());
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Output side: random ready gaps, eager stretches, and one long hold-off.
    initial begin
        int  gap;
        bit  held;
        held = 1'b0;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && words_out >= HOLD_AT_WORD) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (words_out % 128 == 0) begin
                rx_eager = ($urandom_range(0, 2) == 0);
            end
            gap = rx_eager ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : check_output
        rgb_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (rgb_expected.size() == 0) begin
                note_failure($sformatf("unexpected output word r=%0d g=%0d b=%0d",
                                       m_red, m_green, m_blue));
            end else begin
                want = rgb_expected.pop_front();
                if (m_red !== want.rgb.red || m_green !== want.rgb.green ||
                    m_blue !== want.rgb.blue) begin
                    note_failure($sformatf(
                        "hue %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        want.hue, want.rgb.red, want.rgb.green, want.rgb.blue,
                        m_red, m_green, m_blue));
                end
            end
        end
    end

    // End the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

### sim.f
sv/hsv_pkg.sv
sv/hsv_pipe_ctl.sv
sv/hsv_hue.sv
sv/hsv_chan.sv
sv/hsv_to_rgb_converter.sv
tb/sv/tb_top.sv
